// File: hdl/vpm_pkg.sv
// ----------------------------------------------------------------------------
// vpm_pkg
// Shared widths, constants and the CORDIC arctangent table of the vortex
// phase modulator.
// ----------------------------------------------------------------------------
`default_nettype none

package vpm_pkg;

  localparam int COORD_WIDTH     = 16;
  localparam int AMP_WIDTH       = 16;
  localparam int PHASE_BITS      = 16;
  localparam int MAX_ROWS        = 4096;
  localparam int ROW_WIDTH       = 12;
  localparam int ROWS_CFG_WIDTH  = 13;
  localparam int CHARGE_WIDTH    = 16;
  localparam int CFG_DATA_WIDTH  = 16;
  localparam int STEPS           = 32;
  localparam int VEC_WIDTH       = 64;
  localparam int VEC_SHIFT       = 60 - COORD_WIDTH;
  localparam int ANG_WIDTH       = 34;
  localparam int THETA_WIDTH     = PHASE_BITS + 3;
  localparam int PROD_WIDTH      = THETA_WIDTH + CHARGE_WIDTH;
  localparam int ROT_WIDTH       = 36;
  localparam int ROT_FRAC        = 16;
  localparam int OUT_WIDTH       = AMP_WIDTH + 1;
  localparam int IN_TDATA_WIDTH  = 64;
  localparam int OUT_TDATA_WIDTH = 40;

  localparam logic [31:0] INV_GAIN = 32'h9B74EDA8;

  localparam logic [CHARGE_WIDTH-1:0]   CHARGE_RESET    = 16'd256;
  localparam logic [ROWS_CFG_WIDTH-1:0] ROW_COUNT_RESET = 13'd1024;

  typedef enum logic [0:0] {
    REG_CHARGE    = 1'b0,
    REG_ROW_COUNT = 1'b1
  } cfg_reg_t;

  // Arctangent of 2^-step in turns scaled by 2^32, rounded to nearest.
  function automatic logic signed [ANG_WIDTH-1:0] atan_turns(input logic [4:0] step);
    logic signed [ANG_WIDTH-1:0] a;
    case (step)
      5'd0:  a = 34'sd536870912;
      5'd1:  a = 34'sd316933406;
      5'd2:  a = 34'sd167458907;
      5'd3:  a = 34'sd85004756;
      5'd4:  a = 34'sd42667331;
      5'd5:  a = 34'sd21354465;
      5'd6:  a = 34'sd10679838;
      5'd7:  a = 34'sd5340245;
      5'd8:  a = 34'sd2670163;
      5'd9:  a = 34'sd1335087;
      5'd10: a = 34'sd667544;
      5'd11: a = 34'sd333772;
      5'd12: a = 34'sd166886;
      5'd13: a = 34'sd83443;
      5'd14: a = 34'sd41722;
      5'd15: a = 34'sd20861;
      5'd16: a = 34'sd10430;
      5'd17: a = 34'sd5215;
      5'd18: a = 34'sd2608;
      5'd19: a = 34'sd1304;
      5'd20: a = 34'sd652;
      5'd21: a = 34'sd326;
      5'd22: a = 34'sd163;
      5'd23: a = 34'sd81;
      5'd24: a = 34'sd41;
      5'd25: a = 34'sd20;
      5'd26: a = 34'sd10;
      5'd27: a = 34'sd5;
      5'd28: a = 34'sd3;
      5'd29: a = 34'sd1;
      5'd30: a = 34'sd1;
      default: a = 34'sd0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// File: hdl/vortex_phase_modulator.sv
// ----------------------------------------------------------------------------
// vortex_phase_modulator
// Spiral phase modulation of one grid point per transfer: a vectoring CORDIC
// finds the point's angle, the charge scales it, and a rotation CORDIC turns
// the amplitude by the resulting phase.
// ----------------------------------------------------------------------------
// Usage:
// Grid points arrive on the s_ channel, one per transfer. Each transfer gives
// exactly one complex sample on the m_ channel, in arrival order.
// The cfg port writes charge (index 0) and row_count (index 1); write them
// only while no transfer is in flight.
// Throughput is one point per cycle while s_tready is high. The pipeline
// has 69 register stages: an input stage, 32 vectoring steps, a rounding
// stage, the charge multiplier, a quadrant fold, 32 rotation steps and a
// saturation stage, followed by the output register that drives m_tdata.
// The output register has a one-entry skid buffer behind it. When the
// receiver stalls, the pipeline keeps moving until a result meets the held
// output register; that result goes into the skid entry, s_tready drops and
// the whole pipeline holds until the skid entry drains.
// Synchronous reset empties the pipeline and sets charge to 1.0 (256 in
// Q8.8) and row_count to 1024.
// ----------------------------------------------------------------------------
`default_nettype none

module vortex_phase_modulator
  import vpm_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [0:0]                 cfg_addr,
  input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  // x_coord[15:0], y_coord[31:16], row_index[43:32], amplitude[59:44], zeros
  input  wire logic [IN_TDATA_WIDTH-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  // real_part[16:0], imag_part[33:17], zeros
  output logic [OUT_TDATA_WIDTH-1:0]      m_tdata
);

  logic [CHARGE_WIDTH-1:0]   charge;
  logic [ROWS_CFG_WIDTH-1:0] row_count;
  logic [ROWS_CFG_WIDTH-1:0] rows_eff;
  logic [ROW_WIDTH-1:0]      row_half;

  always_ff @(posedge clk) begin
    if (rst) begin
      charge    <= CHARGE_RESET;
      row_count <= ROW_COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_CHARGE:    charge    <= cfg_data;
        REG_ROW_COUNT: row_count <= cfg_data[ROWS_CFG_WIDTH-1:0];
      endcase
    end
  end

  always_comb begin
    rows_eff = (row_count > ROWS_CFG_WIDTH'(MAX_ROWS)) ? ROWS_CFG_WIDTH'(MAX_ROWS) : row_count;
    row_half = rows_eff[ROWS_CFG_WIDTH-1:1];
  end

  logic en;
  logic skid_valid;
  assign en       = !skid_valid;
  assign s_tready = en;

  // Input stage.
  logic signed [COORD_WIDTH-1:0] x_in, y_in;
  logic [ROW_WIDTH-1:0]          row_in;
  logic [AMP_WIDTH-1:0]          amp_in;
  logic signed [VEC_WIDTH-1:0]   xe, ye, xs, ys;
  logic signed [ANG_WIDTH-1:0]   z0;
  logic [47:0]                   amp_prod;

  always_comb begin
    x_in   = s_tdata[15:0];
    y_in   = s_tdata[31:16];
    row_in = s_tdata[43:32];
    amp_in = s_tdata[59:44];
    xe = VEC_WIDTH'(x_in);
    ye = -VEC_WIDTH'(y_in);
    if (x_in[COORD_WIDTH-1]) begin
      xs = -xe;
      ys = -ye;
      z0 = ye[VEC_WIDTH-1] ? -(34'sd1 <<< 31) : (34'sd1 <<< 31);
    end else begin
      xs = xe;
      ys = ye;
      z0 = '0;
    end
    amp_prod = {32'b0, amp_in} * {16'b0, INV_GAIN};
  end

  // Vectoring CORDIC stages.
  logic signed [VEC_WIDTH-1:0] vx [0:STEPS];
  logic signed [VEC_WIDTH-1:0] vy [0:STEPS];
  logic signed [ANG_WIDTH-1:0] vz [0:STEPS];
  logic [31:0]                 vamp [0:STEPS];
  logic                        vorg [0:STEPS];
  logic                        vlow [0:STEPS];
  logic                        vvld [0:STEPS];
  logic signed [VEC_WIDTH-1:0] vx_next [0:STEPS-1];
  logic signed [VEC_WIDTH-1:0] vy_next [0:STEPS-1];
  logic signed [ANG_WIDTH-1:0] vz_next [0:STEPS-1];

  always_comb begin
    for (int k = 0; k < STEPS; k++) begin
      if (!vy[k][VEC_WIDTH-1]) begin
        vx_next[k] = vx[k] + (vy[k] >>> k);
        vy_next[k] = vy[k] - (vx[k] >>> k);
        vz_next[k] = vz[k] + atan_turns(5'(k));
      end else begin
        vx_next[k] = vx[k] - (vy[k] >>> k);
        vy_next[k] = vy[k] + (vx[k] >>> k);
        vz_next[k] = vz[k] - atan_turns(5'(k));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vx[0]   <= xs <<< VEC_SHIFT;
      vy[0]   <= ys <<< VEC_SHIFT;
      vz[0]   <= z0;
      vamp[0] <= amp_prod[47:16];
      vorg[0] <= (x_in == '0) && (y_in == '0);
      vlow[0] <= row_in >= row_half;
      for (int k = 0; k < STEPS; k++) begin
        vx[k+1]   <= vx_next[k];
        vy[k+1]   <= vy_next[k];
        vz[k+1]   <= vz_next[k];
        vamp[k+1] <= vamp[k];
        vorg[k+1] <= vorg[k];
        vlow[k+1] <= vlow[k];
      end
    end
  end

  // Rounding of theta and the row offset.
  logic signed [ANG_WIDTH-1:0]   zrnd;
  logic signed [THETA_WIDTH-1:0] theta_next, theta;
  logic [31:0]                   t_amp;
  logic                          t_valid;

  always_comb begin
    zrnd = vz[STEPS] + (34'sd1 <<< 15);
    theta_next = vorg[STEPS] ? '0 : THETA_WIDTH'($signed(zrnd[ANG_WIDTH-1:16]));
    if (vlow[STEPS]) begin
      theta_next = theta_next + (THETA_WIDTH'(1) <<< PHASE_BITS);
    end
  end

  // Charge multiplier.
  logic signed [PROD_WIDTH-1:0] prod;
  logic [PHASE_BITS-1:0]        phase;
  logic [31:0]                  m_amp;
  logic                         m_valid;

  assign prod = PROD_WIDTH'(theta) * PROD_WIDTH'($signed(charge));

  always_ff @(posedge clk) begin
    if (en) begin
      theta <= theta_next;
      t_amp <= vamp[STEPS];
      phase <= prod[PHASE_BITS+7:8];
      m_amp <= t_amp;
    end
  end

  // Quadrant fold and rotation CORDIC stages.
  logic signed [ANG_WIDTH-1:0] zf;
  logic signed [ROT_WIDTH-1:0] cf;
  logic signed [ROT_WIDTH-1:0] rx [0:STEPS];
  logic signed [ROT_WIDTH-1:0] ry [0:STEPS];
  logic signed [ANG_WIDTH-1:0] rz [0:STEPS];
  logic                        rvld [0:STEPS];
  logic signed [ROT_WIDTH-1:0] rx_next [0:STEPS-1];
  logic signed [ROT_WIDTH-1:0] ry_next [0:STEPS-1];
  logic signed [ANG_WIDTH-1:0] rz_next [0:STEPS-1];

  always_comb begin
    zf = ANG_WIDTH'($signed({phase, 16'h0000}));
    cf = $signed({4'b0, m_amp});
    if (zf > (34'sd1 <<< 30)) begin
      cf = -cf;
      zf = zf - (34'sd1 <<< 31);
    end else if (zf < -(34'sd1 <<< 30)) begin
      cf = -cf;
      zf = zf + (34'sd1 <<< 31);
    end
    for (int k = 0; k < STEPS; k++) begin
      if (!rz[k][ANG_WIDTH-1]) begin
        rx_next[k] = rx[k] - (ry[k] >>> k);
        ry_next[k] = ry[k] + (rx[k] >>> k);
        rz_next[k] = rz[k] - atan_turns(5'(k));
      end else begin
        rx_next[k] = rx[k] + (ry[k] >>> k);
        ry_next[k] = ry[k] - (rx[k] >>> k);
        rz_next[k] = rz[k] + atan_turns(5'(k));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx[0] <= cf;
      ry[0] <= '0;
      rz[0] <= zf;
      for (int k = 0; k < STEPS; k++) begin
        rx[k+1] <= rx_next[k];
        ry[k+1] <= ry_next[k];
        rz[k+1] <= rz_next[k];
      end
    end
  end

  // Rounding and saturation.
  function automatic logic [OUT_WIDTH-1:0] round_sat(input logic signed [ROT_WIDTH-1:0] v);
    logic signed [ROT_WIDTH-1:0] r;
    logic signed [19:0]          q;
    logic [OUT_WIDTH-1:0]        o;
    r = v + (36'sd1 <<< (ROT_FRAC - 1));
    q = r[ROT_WIDTH-1:ROT_FRAC];
    if (q > 20'sd65535) begin
      o = {1'b0, {AMP_WIDTH{1'b1}}};
    end else if (q < -20'sd65536) begin
      o = {1'b1, {AMP_WIDTH{1'b0}}};
    end else begin
      o = q[OUT_WIDTH-1:0];
    end
    return o;
  endfunction

  logic [OUT_WIDTH-1:0] p_real, p_imag;
  logic                 p_valid;

  always_ff @(posedge clk) begin
    if (en) begin
      p_real <= round_sat(rx[STEPS]);
      p_imag <= round_sat(ry[STEPS]);
    end
  end

  // Valid bits of all stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= STEPS; k++) begin
        vvld[k] <= 1'b0;
        rvld[k] <= 1'b0;
      end
      t_valid <= 1'b0;
      m_valid <= 1'b0;
      p_valid <= 1'b0;
    end else if (en) begin
      vvld[0] <= s_tvalid;
      for (int k = 0; k < STEPS; k++) begin
        vvld[k+1] <= vvld[k];
        rvld[k+1] <= rvld[k];
      end
      t_valid <= vvld[STEPS];
      m_valid <= t_valid;
      rvld[0] <= m_valid;
      p_valid <= rvld[STEPS];
    end
  end

  // Output register with skid entry.
  logic                 out_valid;
  logic [OUT_WIDTH-1:0] out_real, out_imag;
  logic [OUT_WIDTH-1:0] skid_real, skid_imag;
  logic                 down_free;
  logic                 up_xfer;

  assign down_free = m_tready || !out_valid;
  assign up_xfer   = p_valid && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (down_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= up_xfer;
      end
    end else if (up_xfer) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (down_free) begin
      if (skid_valid) begin
        out_real <= skid_real;
        out_imag <= skid_imag;
      end else begin
        out_real <= p_real;
        out_imag <= p_imag;
      end
    end else if (up_xfer) begin
      skid_real <= p_real;
      skid_imag <= p_imag;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'b0, out_imag, out_real};

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while output register is empty");

  a_skid_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !m_tready))
    else $error("skid entry filled without an output stall");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> (!out_valid && !skid_valid && !p_valid))
    else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire
